[rtl/fl16_pkg.sv]
`default_nettype none

package fl16_pkg;

	// Fletcher modulus and the length of the packet header in bytes.
	localparam logic [7:0] FL_MOD     = 8'd255;
	localparam logic [2:0] HEADER_LEN = 3'd5;

	// Result queue geometry.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_ACK       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_ACTION    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_INFO      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_TELEMETRY = 3'd4;

	// Operating modes.
	localparam logic MODE_CHECK    = 1'b0;
	localparam logic MODE_GENERATE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_CSUM_FAIL    = 2'd1,
		ST_UNKNOWN_TYPE = 2'd2,
		ST_HDR_SHORT    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		KIND_ACK       = 3'd0,
		KIND_ACTION    = 3'd1,
		KIND_INFO      = 3'd2,
		KIND_TELEMETRY = 3'd3,
		KIND_NONE      = 3'd4
	} kind_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] code_ack;
		logic [7:0] code_action;
		logic [7:0] code_info;
		logic [7:0] code_telemetry;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  check_byte;
		logic        final_result;
		status_t     status;
		kind_t       packet_kind;
		logic [31:0] stamp;
	} result_t;

	// Words handed to the result queue in one cycle; word 1 only with word 0.
	typedef struct packed {
		logic [1:0] valid;
		result_t    word1;
		result_t    word0;
	} push_t;

	// Sum of two residues modulo 255; callers keep a + b below 510.
	function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, FL_MOD}) begin
			sum = sum - {1'b0, FL_MOD};
		end
		return sum[7:0];
	endfunction

endpackage

`default_nettype wire

[rtl/fl16_accum.sv]
`default_nettype none

module fl16_accum (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            byte_valid,
	output logic                 byte_stall,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	input  wire fl16_pkg::cfg_t  cfg,
	input  wire logic            space_ok,
	output fl16_pkg::push_t      push
);
	import fl16_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	logic [7:0]  sum_low_q;
	logic [7:0]  sum_high_q;
	logic [2:0]  idx_q;
	logic [7:0]  type_q;
	logic [31:0] stamp_q;

	logic        accept;
	logic        advance;
	logic [7:0]  s_low;
	logic [7:0]  s_high;
	logic [2:0]  idx_next;
	logic [7:0]  type_next;
	logic [31:0] stamp_next;
	kind_t       kind;
	logic [7:0]  check1;
	logic [7:0]  check2;
	result_t     chk_word;

	// The input register moves on once the queue has room for two words.
	assign advance    = valid_s1 && space_ok;
	assign byte_stall = valid_s1 && !space_ok;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Running Fletcher sums.
	always_comb begin
		s_low  = mod255_add(sum_low_q, data_s1);
		s_high = mod255_add(sum_high_q, s_low);
	end

	// Header capture: type byte, then the timestamp little-endian.
	always_comb begin
		idx_next   = (idx_q < HEADER_LEN) ? idx_q + 3'd1 : idx_q;
		type_next  = (idx_q == 3'd0) ? data_s1 : type_q;
		stamp_next = stamp_q;
		unique case (idx_q)
			3'd1:    stamp_next = stamp_q | {24'd0, data_s1};
			3'd2:    stamp_next = stamp_q | {16'd0, data_s1, 8'd0};
			3'd3:    stamp_next = stamp_q | {8'd0, data_s1, 16'd0};
			3'd4:    stamp_next = stamp_q | {data_s1, 24'd0};
			default: stamp_next = stamp_q;
		endcase
	end

	// Type lookup; the lowest matching kind wins when codes are equal.
	always_comb begin
		priority if (type_next == cfg.code_ack) begin
			kind = KIND_ACK;
		end else if (type_next == cfg.code_action) begin
			kind = KIND_ACTION;
		end else if (type_next == cfg.code_info) begin
			kind = KIND_INFO;
		end else if (type_next == cfg.code_telemetry) begin
			kind = KIND_TELEMETRY;
		end else begin
			kind = KIND_NONE;
		end
	end

	// Check bytes that make the appended packet sum to zero.
	always_comb begin
		check1 = FL_MOD - mod255_add(s_low, s_high);
		check2 = FL_MOD - mod255_add(s_low, check1);
	end

	// Status word for check mode.
	always_comb begin
		chk_word              = '0;
		chk_word.final_result = 1'b1;
		chk_word.packet_kind  = KIND_NONE;
		if (s_low != 8'd0 || s_high != 8'd0) begin
			chk_word.status = ST_CSUM_FAIL;
		end else if (kind == KIND_NONE) begin
			chk_word.status = ST_UNKNOWN_TYPE;
		end else if (idx_next < HEADER_LEN) begin
			chk_word.status      = ST_HDR_SHORT;
			chk_word.packet_kind = kind;
		end else begin
			chk_word.status      = ST_OK;
			chk_word.packet_kind = kind;
			chk_word.stamp       = stamp_next;
		end
	end

	// Words pushed on the last byte of a packet.
	always_comb begin
		push                    = '0;
		push.word0.packet_kind  = KIND_NONE;
		push.word1.packet_kind  = KIND_NONE;
		if (advance && last_s1) begin
			if (cfg.mode == MODE_GENERATE) begin
				push.valid                   = 2'b11;
				push.word0.check_byte        = check1;
				push.word1.check_byte        = check2;
				push.word1.final_result      = 1'b1;
			end else begin
				push.valid = 2'b01;
				push.word0 = chk_word;
			end
		end
	end

	// Packet state; the last byte returns it to the start of a packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q  <= 8'd0;
			sum_high_q <= 8'd0;
			idx_q      <= 3'd0;
			type_q     <= 8'd0;
			stamp_q    <= 32'd0;
		end else if (advance) begin
			if (last_s1) begin
				sum_low_q  <= 8'd0;
				sum_high_q <= 8'd0;
				idx_q      <= 3'd0;
				type_q     <= 8'd0;
				stamp_q    <= 32'd0;
			end else begin
				sum_low_q  <= s_low;
				sum_high_q <= s_high;
				idx_q      <= idx_next;
				type_q     <= type_next;
				stamp_q    <= stamp_next;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		sum_low_q != FL_MOD && sum_high_q != FL_MOD)
		else $error("running sum left unreduced");

	a_idx_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= HEADER_LEN)
		else $error("byte index past header length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (idx_q == 3'd0 && sum_low_q == 8'd0 && stamp_q == 32'd0))
		else $error("packet state not cleared after last byte");
`endif

endmodule

`default_nettype wire

[rtl/fl16_result_queue.sv]
`default_nettype none

module fl16_result_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fl16_pkg::push_t  push,
	output logic                  space_ok,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output fl16_pkg::result_t     head
);
	import fl16_pkg::*;

	result_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QCNT_W-1:0]   n_push;

	assign result_valid = (count_q != '0);
	assign pop          = result_valid && !result_stall;
	assign head         = entry_q[rd_ptr_q];
	assign space_ok     = (count_q <= QCNT_W'(QDEPTH - 2));
	assign n_push       = QCNT_W'(push.valid[0]) + QCNT_W'(push.valid[1]);

	// Entry storage; up to two words written per cycle.
	always_ff @(posedge clk) begin
		if (push.valid[0]) begin
			entry_q[wr_ptr_q] <= push.word0;
		end
		if (push.valid[1]) begin
			entry_q[wr_ptr_q + QPTR_W'(1)] <= push.word1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[QPTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + n_push - QCNT_W'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid[0] |-> count_q <= QCNT_W'(QDEPTH - 2))
		else $error("word pushed into a queue without room");

	a_pair_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid[1] |-> push.valid[0])
		else $error("second word pushed without the first");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.valid == 2'b00) |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("fill count wrong after a pop");
`endif

endmodule

`default_nettype wire

[rtl/fletcher16_packet_checker_unit.sv]
// Fletcher-16 packet checker: one packet byte per word on the input channel.
// A result word passes through the input register and then the result queue before it is valid.
// Throughput: one byte per cycle unless the input stalls for lack of queue room, set by the mod-255 accumulate stage.
// Generate mode puts two words into a four-entry result queue; input stalls at three.
// Reset: arst_n clears packet state, the queue and the registers to their defaults.
`default_nettype none

module fletcher16_packet_checker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       check_byte,
	output logic             final_result,
	output logic [1:0]       status,
	output logic [2:0]       packet_kind,
	output logic [31:0]      stamp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [fl16_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import fl16_pkg::*;

	cfg_t    cfg_q;
	push_t   push;
	logic    space_ok;
	result_t head;

	// Registers are always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_CHECK;
			cfg_q.code_ack       <= 8'd0;
			cfg_q.code_action    <= 8'd1;
			cfg_q.code_info      <= 8'd2;
			cfg_q.code_telemetry <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:           cfg_q.mode           <= cfg_data[0];
				REG_CODE_ACK:       cfg_q.code_ack       <= cfg_data;
				REG_CODE_ACTION:    cfg_q.code_action    <= cfg_data;
				REG_CODE_INFO:      cfg_q.code_info      <= cfg_data;
				REG_CODE_TELEMETRY: cfg_q.code_telemetry <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	fl16_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.cfg        (cfg_q),
		.space_ok   (space_ok),
		.push       (push)
	);

	fl16_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.space_ok     (space_ok),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	// Result word fields.
	assign check_byte   = head.check_byte;
	assign final_result = head.final_result;
	assign status       = head.status;
	assign packet_kind  = head.packet_kind;
	assign stamp        = head.stamp;

endmodule

`default_nettype wire
